@@ rtl/rtd_temperature_linearizer_defines.svh @@
// Assertion macros used by the checker file.
`ifndef RTD_TEMPERATURE_LINEARIZER_DEFINES_SVH
`define RTD_TEMPERATURE_LINEARIZER_DEFINES_SVH

// Checked at every edge outside reset.
`define RTD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RTD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/rtdlin_pkg.sv @@
`default_nettype none

package rtdlin_pkg;

    localparam int TablePoints = 60;
    localparam int XW          = 12;
    localparam int YW          = 17;
    localparam int IdxW        = $clog2(TablePoints);
    localparam int DivW        = 11;                 // holds the y step
    localparam int CntW        = $clog2(DivW);
    localparam int ProdW       = XW + DivW;
    localparam int SumW        = ProdW + 1;

    localparam logic [YW-1:0]   YFirst = YW'(10000);
    localparam logic [YW-1:0]   YLast  = YW'(128000);
    localparam logic [DivW-1:0] YStep  = DivW'(2000);

    // Calibration points, x descending.
    localparam logic [XW-1:0] X_ROM [0:TablePoints-1] = '{
        12'd3624, 12'd3581, 12'd3534, 12'd3484, 12'd3432,
        12'd3376, 12'd3318, 12'd3256, 12'd3192, 12'd3126,
        12'd3056, 12'd2985, 12'd2911, 12'd2835, 12'd2758,
        12'd2679, 12'd2598, 12'd2517, 12'd2435, 12'd2353,
        12'd2271, 12'd2186, 12'd2106, 12'd2025, 12'd1945,
        12'd1866, 12'd1788, 12'd1711, 12'd1637, 12'd1564,
        12'd1493, 12'd1425, 12'd1358, 12'd1294, 12'd1232,
        12'd1173, 12'd1115, 12'd1060, 12'd1008, 12'd957,
        12'd909,  12'd863,  12'd819,  12'd778,  12'd738,
        12'd700,  12'd664,  12'd630,  12'd598,  12'd569,
        12'd538,  12'd511,  12'd485,  12'd460,  12'd437,
        12'd415,  12'd394,  12'd374,  12'd355,  12'd337
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DIVIDE,
        ST_MULT,
        ST_SUM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic div_init;
        logic div_step;
        logic mult;
        logic sum;
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic found;
        logic div_last;
    } status_t;

endpackage

`default_nettype wire

@@ rtl/rtd_temperature_linearizer.sv @@
// Channel   Ports                              Handshake
// input     adc_code, input_invalid            start & !busy at clk rise
// result    temperature, valid_res             done, one cycle, no backpressure
//
// In-range word: accept runs the one-point-per-cycle table walk, then the
// 11-step serial divider, the multiply, the sum and done. Out-of-range or
// invalid word: the search goes straight to the sum and then to done.
// busy is low only in idle, so a new word is taken the cycle after done.
// Reset (rst_n low, async) returns the controller to idle; no pass is needed.
// Results cannot be stalled: done is a single-cycle strobe.
`default_nettype none

module rtd_temperature_linearizer (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [rtdlin_pkg::XW-1:0]    adc_code,
    input  wire logic                         input_invalid,
    output logic                              done,
    output logic [rtdlin_pkg::YW-1:0]         temperature,
    output logic                              valid_res
);

    // controller <-> datapath
    rtdlin_pkg::cmd_t    cmd;
    rtdlin_pkg::status_t status;

    rtdlin_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // table walk, divider, multiplier and result registers
    rtdlin_dp u_dp (
        .clk           (clk),
        .cmd           (cmd),
        .adc_code      (adc_code),
        .input_invalid (input_invalid),
        .status        (status),
        .temperature   (temperature),
        .valid_res     (valid_res)
    );

endmodule

`default_nettype wire

@@ rtl/rtdlin_ctrl.sv @@
`default_nettype none

module rtdlin_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire rtdlin_pkg::status_t status,
    output rtdlin_pkg::cmd_t       cmd,
    output logic                   busy,
    output logic                   done
);

    rtdlin_pkg::state_t state_reg;
    rtdlin_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rtdlin_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            rtdlin_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = rtdlin_pkg::ST_SEARCH;
                end
            end
            rtdlin_pkg::ST_SEARCH:
            begin
                if (status.bad)
                begin
                    state_next = rtdlin_pkg::ST_SUM;
                end
                else if (status.found)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = rtdlin_pkg::ST_DIVIDE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            rtdlin_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = rtdlin_pkg::ST_MULT;
                end
            end
            rtdlin_pkg::ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = rtdlin_pkg::ST_SUM;
            end
            rtdlin_pkg::ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = rtdlin_pkg::ST_DONE;
            end
            rtdlin_pkg::ST_DONE:
            begin
                done       = 1'b1;
                state_next = rtdlin_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rtdlin_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/rtdlin_dp.sv @@
`default_nettype none

module rtdlin_dp (
    input  wire logic                          clk,
    input  wire rtdlin_pkg::cmd_t              cmd,
    input  wire logic [rtdlin_pkg::XW-1:0]     adc_code,
    input  wire logic                          input_invalid,
    output rtdlin_pkg::status_t                status,
    output logic [rtdlin_pkg::YW-1:0]          temperature,
    output logic                               valid_res
);

    logic [rtdlin_pkg::XW-1:0]    code_reg,        code_next;
    logic                         bad_reg,         bad_next;
    logic [rtdlin_pkg::IdxW-1:0]  idx_reg,         idx_next;
    logic [rtdlin_pkg::XW-1:0]    x_prev_reg,      x_prev_next;
    logic [rtdlin_pkg::YW-1:0]    y_prev_reg,      y_prev_next;
    logic [rtdlin_pkg::XW-1:0]    divisor_reg,     divisor_next;
    logic [rtdlin_pkg::XW-1:0]    rem_reg,         rem_next;
    logic [rtdlin_pkg::DivW-1:0]  quo_reg,         quo_next;
    logic [rtdlin_pkg::CntW-1:0]  cnt_reg,         cnt_next;
    logic [rtdlin_pkg::ProdW-1:0] prod_reg,        prod_next;
    logic [rtdlin_pkg::YW-1:0]    temperature_reg, temperature_next;
    logic                         valid_reg,       valid_next;

    logic [rtdlin_pkg::XW-1:0]    x_cur;
    logic [rtdlin_pkg::XW:0]      shifted;
    logic [rtdlin_pkg::XW-1:0]    diff;
    logic [rtdlin_pkg::DivW-1:0]  slope;
    logic [rtdlin_pkg::SumW-1:0]  sum;
    logic                         ok;

    assign x_cur   = rtdlin_pkg::X_ROM[idx_reg];
    assign shifted = {rem_reg, quo_reg[rtdlin_pkg::DivW-1]};
    assign diff    = x_prev_reg - code_reg;
    assign slope   = (divisor_reg == '0) ? '0 : quo_reg;
    assign sum     = rtdlin_pkg::SumW'(y_prev_reg) + rtdlin_pkg::SumW'(prod_reg);
    assign ok      = !bad_reg
                     && (sum != rtdlin_pkg::SumW'(rtdlin_pkg::YFirst))
                     && (sum != rtdlin_pkg::SumW'(rtdlin_pkg::YLast));

    assign status.bad      = bad_reg;
    assign status.found    = code_reg > x_cur;
    assign status.div_last = cnt_reg == rtdlin_pkg::CntW'(rtdlin_pkg::DivW - 1);

    assign temperature = temperature_reg;
    assign valid_res   = valid_reg;

    always_comb
    begin
        code_next        = code_reg;
        bad_next         = bad_reg;
        idx_next         = idx_reg;
        x_prev_next      = x_prev_reg;
        y_prev_next      = y_prev_reg;
        divisor_next     = divisor_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        cnt_next         = cnt_reg;
        prod_next        = prod_reg;
        temperature_next = temperature_reg;
        valid_next       = valid_reg;

        if (cmd.load)
        begin
            code_next   = adc_code;
            bad_next    = input_invalid
                          || (adc_code >= rtdlin_pkg::X_ROM[0])
                          || (adc_code <= rtdlin_pkg::X_ROM[rtdlin_pkg::TablePoints-1]);
            idx_next    = rtdlin_pkg::IdxW'(1);
            x_prev_next = rtdlin_pkg::X_ROM[0];
            y_prev_next = rtdlin_pkg::YFirst;
        end

        // walk one table point per cycle
        if (cmd.step)
        begin
            idx_next    = idx_reg + 1'b1;
            x_prev_next = x_cur;
            y_prev_next = y_prev_reg + rtdlin_pkg::YW'(rtdlin_pkg::YStep);
        end

        if (cmd.div_init)
        begin
            divisor_next = x_prev_reg - x_cur;
            rem_next     = '0;
            quo_next     = rtdlin_pkg::YStep;
            cnt_next     = '0;
        end

        // restoring division, one quotient bit per cycle
        if (cmd.div_step)
        begin
            if (shifted >= {1'b0, divisor_reg})
            begin
                rem_next = rtdlin_pkg::XW'(shifted - {1'b0, divisor_reg});
                quo_next = {quo_reg[rtdlin_pkg::DivW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[rtdlin_pkg::XW-1:0];
                quo_next = {quo_reg[rtdlin_pkg::DivW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
        end

        if (cmd.mult)
        begin
            prod_next = rtdlin_pkg::ProdW'(diff) * rtdlin_pkg::ProdW'(slope);
        end

        if (cmd.sum)
        begin
            valid_next       = ok;
            temperature_next = ok ? sum[rtdlin_pkg::YW-1:0] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg        <= code_next;
        bad_reg         <= bad_next;
        idx_reg         <= idx_next;
        x_prev_reg      <= x_prev_next;
        y_prev_reg      <= y_prev_next;
        divisor_reg     <= divisor_next;
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
        cnt_reg         <= cnt_next;
        prod_reg        <= prod_next;
        temperature_reg <= temperature_next;
        valid_reg       <= valid_next;
    end

endmodule

`default_nettype wire

@@ rtl/rtdlin_checker.sv @@
`default_nettype none
`include "rtd_temperature_linearizer_defines.svh"

module rtdlin_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic                      done,
    input wire logic [rtdlin_pkg::YW-1:0] temperature,
    input wire logic                      valid_res
);

    `RTD_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
    `RTD_ASSERT(a_done_single, done |=> !done, "done held longer than one cycle")
    `RTD_ASSERT(a_invalid_zero, (done && !valid_res) |-> (temperature == '0), "invalid result not zero")
    `RTD_ASSERT(a_valid_inside, (done && valid_res) |-> ((temperature > rtdlin_pkg::YFirst) && (temperature < rtdlin_pkg::YLast)), "valid result outside table")
    `RTD_ASSERT_ALWAYS(a_done_busy, done |-> busy, "done outside a busy period")

endmodule

bind rtd_temperature_linearizer rtdlin_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .temperature (temperature),
    .valid_res   (valid_res)
);

`default_nettype wire
